// ----- hw/rtl/si_pkg.sv -----
// si_pkg: shared types for the segment intersection pipeline.
// No dependencies; imported by si_geom, si_scale, si_div and segment_intersection.
`default_nettype none
package si_pkg;

    // Control that travels beside each word; hit joins valid at the last si_geom stage.
    typedef struct packed {
        logic valid;
        logic hit;
    } t_ctl;

endpackage
`default_nettype wire

// ----- hw/rtl/si_geom.sv -----
// si_geom: differences, cross products, sign normalization and the range test.
// Four register stages; depends on si_pkg.
`default_nettype none
module si_geom
    import si_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic signed [COORD_WIDTH-1:0]     i_a_start_x,
    input  wire logic signed [COORD_WIDTH-1:0]     i_a_start_y,
    input  wire logic signed [COORD_WIDTH-1:0]     i_a_end_x,
    input  wire logic signed [COORD_WIDTH-1:0]     i_a_end_y,
    input  wire logic signed [COORD_WIDTH-1:0]     i_b_start_x,
    input  wire logic signed [COORD_WIDTH-1:0]     i_b_start_y,
    input  wire logic signed [COORD_WIDTH-1:0]     i_b_end_x,
    input  wire logic signed [COORD_WIDTH-1:0]     i_b_end_y,
    output t_ctl                                   o_ctl,
    output logic [2*COORD_WIDTH+1:0]               o_den,
    output logic [2*COORD_WIDTH+1:0]               o_tn,
    output logic [COORD_WIDTH-1:0]                 o_mag_x,
    output logic [COORD_WIDTH-1:0]                 o_mag_y,
    output logic                                   o_neg_x,
    output logic                                   o_neg_y,
    output logic signed [COORD_WIDTH-1:0]          o_base_x,
    output logic signed [COORD_WIDTH-1:0]          o_base_y
);
    localparam int D = COORD_WIDTH + 1;
    localparam int P = 2 * D + 1;

    // stage 1: differences
    logic                    r1_v;
    logic signed [D-1:0]     r1_s1x, r1_s1y, r1_s2x, r1_s2y, r1_dx, r1_dy;
    logic signed [COORD_WIDTH-1:0] r1_bx, r1_by;
    // stage 2: products
    logic                    r2_v;
    logic signed [2*D-1:0]   r2_da, r2_db, r2_sa, r2_sb, r2_ta, r2_tb;
    logic signed [D-1:0]     r2_s1x, r2_s1y;
    logic signed [COORD_WIDTH-1:0] r2_bx, r2_by;
    // stage 3: sums
    logic                    r3_v;
    logic signed [P-1:0]     r3_den, r3_sn, r3_tn;
    logic signed [D-1:0]     r3_s1x, r3_s1y;
    logic signed [COORD_WIDTH-1:0] r3_bx, r3_by;
    // stage 4: normalized
    logic                    r4_v, r4_hit;
    logic [P-2:0]            r4_den, r4_tn;
    logic [COORD_WIDTH-1:0]  r4_mx, r4_my;
    logic                    r4_nx, r4_ny;
    logic signed [COORD_WIDTH-1:0] r4_bx, r4_by;

    logic signed [P-1:0]     dn, sn, tn;
    logic signed [D-1:0]     ax, ay;
    logic                    hit;

    always_comb begin
        dn  = r3_den[P-1] ? -r3_den : r3_den;
        sn  = r3_den[P-1] ? -r3_sn  : r3_sn;
        tn  = r3_den[P-1] ? -r3_tn  : r3_tn;
        hit = (r3_den != '0) && !sn[P-1] && (sn <= dn) && !tn[P-1] && (tn <= dn);
        ax  = r3_s1x[D-1] ? -r3_s1x : r3_s1x;
        ay  = r3_s1y[D-1] ? -r3_s1y : r3_s1y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s1x <= $signed({i_a_end_x[COORD_WIDTH-1], i_a_end_x})
                    - $signed({i_a_start_x[COORD_WIDTH-1], i_a_start_x});
            r1_s1y <= $signed({i_a_end_y[COORD_WIDTH-1], i_a_end_y})
                    - $signed({i_a_start_y[COORD_WIDTH-1], i_a_start_y});
            r1_s2x <= $signed({i_b_end_x[COORD_WIDTH-1], i_b_end_x})
                    - $signed({i_b_start_x[COORD_WIDTH-1], i_b_start_x});
            r1_s2y <= $signed({i_b_end_y[COORD_WIDTH-1], i_b_end_y})
                    - $signed({i_b_start_y[COORD_WIDTH-1], i_b_start_y});
            r1_dx  <= $signed({i_a_start_x[COORD_WIDTH-1], i_a_start_x})
                    - $signed({i_b_start_x[COORD_WIDTH-1], i_b_start_x});
            r1_dy  <= $signed({i_a_start_y[COORD_WIDTH-1], i_a_start_y})
                    - $signed({i_b_start_y[COORD_WIDTH-1], i_b_start_y});
            r1_bx  <= i_a_start_x;
            r1_by  <= i_a_start_y;

            r2_da  <= r1_s1x * r1_s2y;
            r2_db  <= r1_s2x * r1_s1y;
            r2_sa  <= r1_s1x * r1_dy;
            r2_sb  <= r1_s1y * r1_dx;
            r2_ta  <= r1_s2x * r1_dy;
            r2_tb  <= r1_s2y * r1_dx;
            r2_s1x <= r1_s1x;
            r2_s1y <= r1_s1y;
            r2_bx  <= r1_bx;
            r2_by  <= r1_by;

            r3_den <= $signed({r2_da[2*D-1], r2_da}) - $signed({r2_db[2*D-1], r2_db});
            r3_sn  <= $signed({r2_sa[2*D-1], r2_sa}) - $signed({r2_sb[2*D-1], r2_sb});
            r3_tn  <= $signed({r2_ta[2*D-1], r2_ta}) - $signed({r2_tb[2*D-1], r2_tb});
            r3_s1x <= r2_s1x;
            r3_s1y <= r2_s1y;
            r3_bx  <= r2_bx;
            r3_by  <= r2_by;

            r4_hit <= hit;
            r4_den <= dn[P-2:0];
            r4_tn  <= tn[P-2:0];
            r4_mx  <= ax[COORD_WIDTH-1:0];
            r4_my  <= ay[COORD_WIDTH-1:0];
            r4_nx  <= r3_s1x[D-1];
            r4_ny  <= r3_s1y[D-1];
            r4_bx  <= r3_bx;
            r4_by  <= r3_by;
        end
    end

    assign o_ctl.valid = r4_v;
    assign o_ctl.hit   = r4_hit;
    assign o_den       = r4_den;
    assign o_tn        = r4_tn;
    assign o_mag_x     = r4_mx;
    assign o_mag_y     = r4_my;
    assign o_neg_x     = r4_nx;
    assign o_neg_y     = r4_ny;
    assign o_base_x    = r4_bx;
    assign o_base_y    = r4_by;
endmodule
`default_nettype wire

// ----- hw/rtl/si_scale.sv -----
// si_scale: tn times the step magnitude for one axis, as two half products.
// Two register stages; depends on si_pkg.
`default_nettype none
module si_scale
    import si_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire t_ctl                              i_ctl,
    input  wire logic [2*COORD_WIDTH+1:0]          i_tn,
    input  wire logic [2*COORD_WIDTH+1:0]          i_den,
    input  wire logic [COORD_WIDTH-1:0]            i_mag,
    input  wire logic                              i_neg,
    input  wire logic signed [COORD_WIDTH-1:0]     i_base,
    output t_ctl                                   o_ctl,
    output logic [3*COORD_WIDTH+1:0]               o_num,
    output logic [2*COORD_WIDTH+1:0]               o_den,
    output logic                                   o_neg,
    output logic signed [COORD_WIDTH-1:0]          o_base
);
    localparam int H  = COORD_WIDTH + 1;
    localparam int NW = 3 * COORD_WIDTH + 2;

    t_ctl                          r1_ctl, r2_ctl;
    logic [H+COORD_WIDTH-1:0]      r1_pl, r1_ph;
    logic [2*COORD_WIDTH+1:0]      r1_den, r2_den;
    logic                          r1_neg, r2_neg;
    logic signed [COORD_WIDTH-1:0] r1_base, r2_base;
    logic [NW-1:0]                 r2_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pl   <= (H+COORD_WIDTH)'(i_tn[H-1:0]) * (H+COORD_WIDTH)'(i_mag);
            r1_ph   <= (H+COORD_WIDTH)'(i_tn[2*H-1:H]) * (H+COORD_WIDTH)'(i_mag);
            r1_den  <= i_den;
            r1_neg  <= i_neg;
            r1_base <= i_base;

            // recombine the halves
            r2_num  <= (NW'(r1_ph) << H) + NW'(r1_pl);
            r2_den  <= r1_den;
            r2_neg  <= r1_neg;
            r2_base <= r1_base;
        end
    end

    assign o_ctl  = r2_ctl;
    assign o_num  = r2_num;
    assign o_den  = r2_den;
    assign o_neg  = r2_neg;
    assign o_base = r2_base;
endmodule
`default_nettype wire

// ----- hw/rtl/si_div.sv -----
// si_div: restoring divider, one quotient bit per stage, then base plus quotient.
// COORD_WIDTH + 1 register stages; depends on si_pkg.
`default_nettype none
module si_div
    import si_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire t_ctl                              i_ctl,
    input  wire logic [3*COORD_WIDTH+1:0]          i_num,
    input  wire logic [2*COORD_WIDTH+1:0]          i_den,
    input  wire logic                              i_neg,
    input  wire logic signed [COORD_WIDTH-1:0]     i_base,
    output t_ctl                                   o_ctl,
    output logic signed [COORD_WIDTH-1:0]          o_coord
);
    localparam int NW = 3 * COORD_WIDTH + 2;
    localparam int DW = 2 * COORD_WIDTH + 2;

    t_ctl                          r_ctl  [0:COORD_WIDTH-1];
    logic [NW-1:0]                 r_rem  [0:COORD_WIDTH-1];
    logic [DW-1:0]                 r_den  [0:COORD_WIDTH-1];
    logic [COORD_WIDTH-1:0]        r_q    [0:COORD_WIDTH-1];
    logic                          r_neg  [0:COORD_WIDTH-1];
    logic signed [COORD_WIDTH-1:0] r_base [0:COORD_WIDTH-1];

    t_ctl                          r_out_ctl;
    logic signed [COORD_WIDTH-1:0] r_out;

    for (genvar k = 0; k < COORD_WIDTH; k++) begin : g_step
        localparam int SH = COORD_WIDTH - 1 - k;
        t_ctl                          ctl_in;
        logic [NW-1:0]                 rem_in, trial, n_rem;
        logic [DW-1:0]                 den_in;
        logic [COORD_WIDTH-1:0]        q_in, n_q;
        logic                          neg_in;
        logic signed [COORD_WIDTH-1:0] base_in;

        if (k == 0) begin : g_first
            assign ctl_in  = i_ctl;
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign q_in    = '0;
            assign neg_in  = i_neg;
            assign base_in = i_base;
        end else begin : g_next
            assign ctl_in  = r_ctl[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign q_in    = r_q[k-1];
            assign neg_in  = r_neg[k-1];
            assign base_in = r_base[k-1];
        end

        // subtract the shifted divisor where it fits
        always_comb begin
            trial   = NW'(den_in) << SH;
            n_rem   = rem_in;
            n_q     = q_in;
            if (rem_in >= trial) begin
                n_rem  = rem_in - trial;
                n_q[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else if (i_en) begin
                r_ctl[k] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= den_in;
                r_q[k]    <= n_q;
                r_neg[k]  <= neg_in;
                r_base[k] <= base_in;
            end
        end
    end

    logic signed [COORD_WIDTH:0] sum;

    always_comb begin
        if (r_neg[COORD_WIDTH-1]) begin
            sum = $signed({r_base[COORD_WIDTH-1][COORD_WIDTH-1], r_base[COORD_WIDTH-1]})
                - $signed({1'b0, r_q[COORD_WIDTH-1]});
        end else begin
            sum = $signed({r_base[COORD_WIDTH-1][COORD_WIDTH-1], r_base[COORD_WIDTH-1]})
                + $signed({1'b0, r_q[COORD_WIDTH-1]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ctl <= '0;
        end else if (i_en) begin
            r_out_ctl <= r_ctl[COORD_WIDTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_ctl[COORD_WIDTH-1].hit ? sum[COORD_WIDTH-1:0] : '0;
        end
    end

    assign o_ctl   = r_out_ctl;
    assign o_coord = r_out;
endmodule
`default_nettype wire

// ----- hw/rtl/segment_intersection.sv -----
// segment_intersection: top level of the parametric segment intersection pipeline.
// Instantiates si_geom, si_scale and si_div; types from si_pkg.
//
//   channel  valid    stall    payload
//   in       i_valid  o_stall  i_a_start_x .. i_b_end_y (signed Q12.12)
//   out      o_valid  i_stall  o_hit, o_cross_x, o_cross_y
//
// One word enters per cycle while the pipeline is not stalled; a word passes through
// four geometry stages, two scaling stages, one divider stage per quotient bit and
// the output register. The divider chain sets the depth.
// Reset (synchronous, active low) clears every valid bit; payload is not reset.
// Stall freezes the whole pipeline at once: advance only while the output register
// is empty or being taken, so no word is dropped or repeated.
`default_nettype none
module segment_intersection
    import si_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_end_y,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_hit,
    output logic signed [COORD_WIDTH-1:0]      o_cross_x,
    output logic signed [COORD_WIDTH-1:0]      o_cross_y
);
    // Geometry -> per-axis scaling
    t_ctl                          geo_ctl;
    logic [2*COORD_WIDTH+1:0]      geo_den, geo_tn;
    logic [COORD_WIDTH-1:0]        geo_mx, geo_my;
    logic                          geo_nx, geo_ny;
    logic signed [COORD_WIDTH-1:0] geo_bx, geo_by;

    // Scaling -> dividers
    t_ctl                          sx_ctl, sy_ctl;
    logic [3*COORD_WIDTH+1:0]      sx_num, sy_num;
    logic [2*COORD_WIDTH+1:0]      sx_den, sy_den;
    logic                          sx_neg, sy_neg;
    logic signed [COORD_WIDTH-1:0] sx_base, sy_base;

    // Divider outputs (the last divider register is the output register)
    t_ctl                          dx_ctl, dy_ctl;
    logic signed [COORD_WIDTH-1:0] dx_coord, dy_coord;

    logic en;

    // Advance everything whenever the output word is absent or being taken.
    assign en      = !dx_ctl.valid || !i_stall;
    assign o_stall = !en;

    si_geom #(.COORD_WIDTH(COORD_WIDTH)) u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_a_start_x (i_a_start_x),
        .i_a_start_y (i_a_start_y),
        .i_a_end_x   (i_a_end_x),
        .i_a_end_y   (i_a_end_y),
        .i_b_start_x (i_b_start_x),
        .i_b_start_y (i_b_start_y),
        .i_b_end_x   (i_b_end_x),
        .i_b_end_y   (i_b_end_y),
        .o_ctl       (geo_ctl),
        .o_den       (geo_den),
        .o_tn        (geo_tn),
        .o_mag_x     (geo_mx),
        .o_mag_y     (geo_my),
        .o_neg_x     (geo_nx),
        .o_neg_y     (geo_ny),
        .o_base_x    (geo_bx),
        .o_base_y    (geo_by)
    );

    si_scale #(.COORD_WIDTH(COORD_WIDTH)) u_scale_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (geo_ctl),
        .i_tn    (geo_tn),
        .i_den   (geo_den),
        .i_mag   (geo_mx),
        .i_neg   (geo_nx),
        .i_base  (geo_bx),
        .o_ctl   (sx_ctl),
        .o_num   (sx_num),
        .o_den   (sx_den),
        .o_neg   (sx_neg),
        .o_base  (sx_base)
    );

    si_scale #(.COORD_WIDTH(COORD_WIDTH)) u_scale_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (geo_ctl),
        .i_tn    (geo_tn),
        .i_den   (geo_den),
        .i_mag   (geo_my),
        .i_neg   (geo_ny),
        .i_base  (geo_by),
        .o_ctl   (sy_ctl),
        .o_num   (sy_num),
        .o_den   (sy_den),
        .o_neg   (sy_neg),
        .o_base  (sy_base)
    );

    si_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (sx_ctl),
        .i_num   (sx_num),
        .i_den   (sx_den),
        .i_neg   (sx_neg),
        .i_base  (sx_base),
        .o_ctl   (dx_ctl),
        .o_coord (dx_coord)
    );

    si_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (sy_ctl),
        .i_num   (sy_num),
        .i_den   (sy_den),
        .i_neg   (sy_neg),
        .i_base  (sy_base),
        .o_ctl   (dy_ctl),
        .o_coord (dy_coord)
    );

    assign o_valid   = dx_ctl.valid;
    assign o_hit     = dx_ctl.hit;
    assign o_cross_x = dx_coord;
    assign o_cross_y = dy_coord;

`ifndef SYNTH
    // Both axis pipelines carry the same words in lockstep.
    a_axis_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dx_ctl == dy_ctl)
        else $error("x and y pipelines out of step");

    // A miss reports the origin.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_cross_x == '0 && o_cross_y == '0)
        else $error("nonzero coordinates on a miss");

    // Input stalls exactly when a finished word waits.
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output backpressure");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !geo_ctl.valid)
        else $error("valid survives reset");
`endif
endmodule
`default_nettype wire

// ----- test/segment_intersection_tb.sv -----
// segment_intersection_tb: self-checking testbench for the segment intersection pipeline.
// Depends on segment_intersection (and si_pkg through it); predicts each result exactly.
`timescale 1ns / 100ps
`default_nettype none

// Holds the expected results of accepted words and compares the block's results in order.
class intersect_scoreboard;
    typedef struct {
        logic             hit;
        logic [23:0]      cx;
        logic [23:0]      cy;
    } t_point;

    t_point pending[$];
    int     errors;

    function new();
        errors = 0;
    endfunction

    // Advance one coordinate from base by trunc(tn * step / den), 0 <= tn <= den, den > 0.
    function automatic logic [23:0] advance_along(longint base, longint step,
                                                  logic signed [127:0] tn,
                                                  logic signed [127:0] den);
        logic [127:0] mag;
        logic [127:0] quo;
        mag = (step < 0) ? -step : step;
        quo = (tn * mag) / den;
        return (step < 0) ? 24'(base - longint'(quo)) : 24'(base + longint'(quo));
    endfunction

    // Note an accepted input word: work out its intersection and queue it.
    function void note_segments(logic signed [23:0] ax0, logic signed [23:0] ay0,
                                logic signed [23:0] ax1, logic signed [23:0] ay1,
                                logic signed [23:0] bx0, logic signed [23:0] by0,
                                logic signed [23:0] bx1, logic signed [23:0] by1);
        longint s1x, s1y, s2x, s2y, dx, dy;
        logic signed [127:0] den, sn, tn;
        t_point p;
        s1x = longint'(ax1) - longint'(ax0);
        s1y = longint'(ay1) - longint'(ay0);
        s2x = longint'(bx1) - longint'(bx0);
        s2y = longint'(by1) - longint'(by0);
        dx  = longint'(ax0) - longint'(bx0);
        dy  = longint'(ay0) - longint'(by0);
        den = 128'(s1x) * 128'(s2y) - 128'(s2x) * 128'(s1y);
        sn  = 128'(s1x) * 128'(dy) - 128'(s1y) * 128'(dx);
        tn  = 128'(s2x) * 128'(dy) - 128'(s2y) * 128'(dx);
        p.hit = 1'b0;
        p.cx  = '0;
        p.cy  = '0;
        if (den != 0) begin
            if (den < 0) begin
                den = -den;
                sn  = -sn;
                tn  = -tn;
            end
            if (sn >= 0 && sn <= den && tn >= 0 && tn <= den) begin
                p.hit = 1'b1;
                p.cx  = advance_along(longint'(ax0), s1x, tn, den);
                p.cy  = advance_along(longint'(ay0), s1y, tn, den);
            end
        end
        pending.insert(pending.size(), p);
    endfunction

    // Check one result against the oldest expectation.
    function void check_result(logic hit, logic [23:0] cx, logic [23:0] cy);
        t_point p;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result hit=%0b x=%h y=%h", $time, hit, cx, cy);
            errors++;
            return;
        end
        p = pending.pop_front();
        if (hit !== p.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, p.hit, hit);
            errors++;
        end
        if (cx !== p.cx) begin
            $display("%0t: cross_x expected %h actual %h", $time, p.cx, cx);
            errors++;
        end
        if (cy !== p.cy) begin
            $display("%0t: cross_y expected %h actual %h", $time, p.cy, cy);
            errors++;
        end
    endfunction
endclass

module segment_intersection_tb;
    localparam int W       = 24;
    localparam int LATENCY = W + 7;
    localparam int N_RAND  = 1530;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic signed [W-1:0] i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y;
    logic signed [W-1:0] i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y;
    logic                o_valid;
    logic                i_stall;
    logic                o_hit;
    logic signed [W-1:0] o_cross_x, o_cross_y;

    intersect_scoreboard board;

    segment_intersection #(.COORD_WIDTH(W)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_a_start_x (i_a_start_x),
        .i_a_start_y (i_a_start_y),
        .i_a_end_x   (i_a_end_x),
        .i_a_end_y   (i_a_end_y),
        .i_b_start_x (i_b_start_x),
        .i_b_start_y (i_b_start_y),
        .i_b_end_x   (i_b_end_x),
        .i_b_end_y   (i_b_end_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hit       (o_hit),
        .o_cross_x   (o_cross_x),
        .o_cross_y   (o_cross_y)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Mostly short gaps, now and then a long one; quiet stretches come from zeros.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Coordinate generator: full range, small values or the extremes.
    function automatic logic [W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return {1'b1, {(W-1){1'b0}}};
            1:       return {1'b0, {(W-1){1'b1}}};
            2, 3:    return W'($signed($urandom_range(0, 2047)) - 1024) <<< 12;
            default: return W'($urandom);
        endcase
    endfunction

    // Drive one word and hold it until accepted; note it in the scoreboard when taken.
    task automatic send_word(logic [W-1:0] ax0, logic [W-1:0] ay0,
                             logic [W-1:0] ax1, logic [W-1:0] ay1,
                             logic [W-1:0] bx0, logic [W-1:0] by0,
                             logic [W-1:0] bx1, logic [W-1:0] by1);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_a_start_x <= ax0;
        i_a_start_y <= ay0;
        i_a_end_x   <= ax1;
        i_a_end_y   <= ay1;
        i_b_start_x <= bx0;
        i_b_start_y <= by0;
        i_b_end_x   <= bx1;
        i_b_end_y   <= by1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_segments(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
    endtask

    // Build a pair that crosses: pick the crossing point and extend both ways.
    task automatic send_crossing();
        logic signed [W-1:0] px, py;
        int ax, ay, bx, by;
        px = W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        py = W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        ax = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        ay = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        bx = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        by = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        send_word(W'(px - ax), W'(py - ay), W'(px + ax), W'(py + ay),
                  W'(px - bx), W'(py - by), W'(px + bx), W'(py + by));
    endtask

    // Drop the sender until every expected result has come out.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls; check each word taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                board.check_result(o_hit, o_cross_x, o_cross_y);
        end
    end

    initial begin : stall_driver
        int gap;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = gap_length();
            i_stall <= (gap > 0);
            repeat (gap > 0 ? gap : $urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    initial begin
        board        = new();
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        {i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y} = '0;
        {i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y} = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: plain crossing, endpoint touch, T junction, parallel, collinear,
        // degenerate point, miss, and full-scale extremes in every field.
        send_word(-24'sd4096, 0, 24'sd4096, 0, 0, -24'sd4096, 0, 24'sd4096);
        send_word(0, 0, 24'sd8192, 24'sd8192, 24'sd8192, 24'sd8192, 24'sd16384, 0);
        send_word(0, 0, 24'sd8192, 0, 24'sd4096, 0, 24'sd4096, 24'sd8192);
        send_word(0, 0, 24'sd8192, 0, 0, 24'sd4096, 24'sd8192, 24'sd4096);
        send_word(0, 0, 24'sd8192, 0, 24'sd4096, 0, 24'sd12288, 0);
        send_word(24'sd100, 24'sd100, 24'sd100, 24'sd100, 0, 0, 24'sd200, 24'sd200);
        send_word(0, 0, 24'sd4096, 24'sd4096, 24'sd8192, 0, 24'sd8192, 24'sd4096);
        send_word(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff,
                  24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000);
        send_word(24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff,
                  24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000);
        send_word(24'h800000, 24'h7fffff, 24'h800000, 24'h800000,
                  24'h7fffff, 24'h000000, 24'h800000, 24'h000001);
        send_word(24'hffffff, 24'hffffff, 24'h000001, 24'h000001,
                  24'hffffff, 24'h000001, 24'h000001, 24'hffffff);
        send_word(24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555,
                  24'h555555, 24'h555555, 24'haaaaaa, 24'haaaaaa);
        send_word(0, 0, 24'sd3, 24'sd7, 24'sd3, 0, 0, 24'sd7);
        send_word(0, 0, 24'sd7, 24'sd3, 24'sd7, 0, 0, 24'sd3);
        send_word(0, 0, -24'sd7, 24'sd3, -24'sd7, 0, 0, 24'sd3);
        drain();

        // Random: mostly real crossings, the rest arbitrary pairs.
        for (int n = 0; n < N_RAND; n++) begin
            if (n == N_RAND / 2) drain();
            if ($urandom_range(0, 99) < 60)
                send_crossing();
            else
                send_word(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                          pick_coord(), pick_coord(), pick_coord(), pick_coord());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Bound the run well beyond the slowest correct one.
    initial begin : watchdog
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

`default_nettype wire

// ----- segment_intersection.f -----
hw/rtl/si_pkg.sv
hw/rtl/si_geom.sv
hw/rtl/si_scale.sv
hw/rtl/si_div.sv
hw/rtl/segment_intersection.sv
test/segment_intersection_tb.sv
